>>> rtl/core/slm_pkg.sv
// Package with widths, reset values, state encoding and shared types for the supply model.
package slm_pkg;

  localparam int unsigned MV_W    = 16;
  localparam int unsigned MA_W    = 26;
  localparam int unsigned LOAD_W  = 24;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_W   = 26;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SCALE_W = 10;
  localparam int unsigned QCNT_W  = $clog2(MA_W);

  localparam logic [SCALE_W-1:0] MV_TO_MA_SCALE = SCALE_W'(1000);

  localparam logic [MV_W-1:0] RESET_MIN_MV     = MV_W'(0);
  localparam logic [MV_W-1:0] RESET_MAX_MV     = MV_W'(60000);
  localparam logic [MV_W-1:0] RESET_STEP_MV    = MV_W'(50);
  localparam logic [MA_W-1:0] RESET_LIMIT_MA   = MA_W'(0);
  localparam logic [MV_W-1:0] RESET_TARGET_MV  = MV_W'(13500);

  typedef enum logic [1:0] {
    MODE_SETPOINT = 2'd0,
    MODE_ENABLE   = 2'd1,
    MODE_LOAD     = 2'd2,
    MODE_TICK     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MIN_MV   = 2'd0,
    REG_MAX_MV   = 2'd1,
    REG_STEP_MV  = 2'd2,
    REG_LIMIT_MA = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_CHECK,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/core/slm_div.sv
// Radix-2 restoring divider that yields one quotient bit per cycle.
module slm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [slm_pkg::MA_W-1:0]     dividend,
  input  logic [slm_pkg::LOAD_W-1:0]   divisor,
  output logic [slm_pkg::MA_W-1:0]     quotient,
  output slm_pkg::div_status_t         status
);

  logic [slm_pkg::LOAD_W-1:0] rem;
  logic [slm_pkg::MA_W-1:0]   work;
  logic [slm_pkg::QCNT_W-1:0] count;
  logic                       busy;
  logic                       done;
  logic [slm_pkg::LOAD_W:0]   rem_shift;
  logic [slm_pkg::LOAD_W:0]   rem_diff;
  logic                       fits;

  always_comb begin
    rem_shift = {rem, work[slm_pkg::MA_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    fits      = (rem_shift >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= slm_pkg::QCNT_W'(slm_pkg::MA_W - 1);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      work <= dividend;
    end else if (busy) begin
      rem  <= fits ? rem_diff[slm_pkg::LOAD_W-1:0] : rem_shift[slm_pkg::LOAD_W-1:0];
      work <= {work[slm_pkg::MA_W-2:0], fits};
    end
  end

  assign quotient    = work;
  assign status.busy = busy;
  assign status.done = done;

endmodule

>>> rtl/core/slew_limited_supply_model.sv
// Top level of the slew-limited supply model: state, sequencer and output words.
//
//   channel  signals                          direction  payload
//   cfg      cfg_we, cfg_index, cfg_data      in         register write
//   in       in_valid, in_ready               in         mode, value
//   out      out_valid, out_ready             out        voltage_mv, current_ma
//
// A setpoint, enable or load word updates its register when accepted. A tick steps
// through MUL, START, DIV (only with a load connected, while the bit-serial divider
// yields its 26 quotient bits and its done flag), CHECK and SEND, where the result
// word waits to be taken; an open circuit skips DIV and an unchanged result skips SEND.
// Reset sets the registers, model state and control, but not product or divider data.
// The block takes no input word until the result word of a tick has been taken.
module slew_limited_supply_model (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [slm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slm_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [slm_pkg::MODE_W-1:0]   mode,
  input  logic signed [slm_pkg::VALUE_W-1:0] value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [slm_pkg::MV_W-1:0]     voltage_mv,
  output logic [slm_pkg::MA_W-1:0]     current_ma
);

  logic [slm_pkg::MV_W-1:0]   min_mv;
  logic [slm_pkg::MV_W-1:0]   max_mv;
  logic [slm_pkg::MV_W-1:0]   ramp_step_mv;
  logic [slm_pkg::MA_W-1:0]   current_limit_ma;

  logic [slm_pkg::MV_W-1:0]   target_mv;
  logic                       output_on;
  logic [slm_pkg::LOAD_W-1:0] load_mohm;
  logic [slm_pkg::MV_W-1:0]   present_mv;
  logic [slm_pkg::MV_W-1:0]   present_mv_next;
  logic [slm_pkg::MV_W-1:0]   sent_mv;
  logic [slm_pkg::MA_W-1:0]   sent_ma;
  logic                       sent_valid;
  logic [slm_pkg::MA_W-1:0]   product;

  slm_pkg::state_t            state;
  slm_pkg::state_t            state_next;

  logic                       accept;
  logic                       div_start;
  logic [slm_pkg::MA_W-1:0]   quotient;
  slm_pkg::div_status_t       div_status;

  logic [slm_pkg::MV_W-1:0]   goal_mv;
  logic [slm_pkg::MV_W-1:0]   gap_mv;
  logic                       rising;
  logic                       below_min;
  logic                       above_max;
  logic [slm_pkg::MV_W-1:0]   clamped_mv;
  logic [slm_pkg::LOAD_W-1:0] load_value;
  logic [slm_pkg::MA_W-1:0]   amps_raw;
  logic [slm_pkg::MA_W-1:0]   amps;
  logic                       unchanged;

  assign accept = in_valid && in_ready;

  always_comb begin
    below_min = value[slm_pkg::VALUE_W-1]
      || ((value[slm_pkg::VALUE_W-2:slm_pkg::MV_W] == '0)
          && (value[slm_pkg::MV_W-1:0] < min_mv));
    above_max = !value[slm_pkg::VALUE_W-1]
      && ((value[slm_pkg::VALUE_W-2:slm_pkg::MV_W] != '0)
          || (value[slm_pkg::MV_W-1:0] > max_mv));
    priority if (below_min) begin
      clamped_mv = min_mv;
    end else if (above_max) begin
      clamped_mv = max_mv;
    end else begin
      clamped_mv = value[slm_pkg::MV_W-1:0];
    end
    priority if (value[slm_pkg::VALUE_W-1]) begin
      load_value = '0;
    end else if (value[slm_pkg::VALUE_W-2:slm_pkg::LOAD_W] != '0) begin
      load_value = '1;
    end else begin
      load_value = value[slm_pkg::LOAD_W-1:0];
    end
  end

  always_comb begin
    goal_mv = output_on ? target_mv : '0;
    rising  = (goal_mv >= present_mv);
    gap_mv  = rising ? (goal_mv - present_mv) : (present_mv - goal_mv);
    priority if (gap_mv <= ramp_step_mv) begin
      present_mv_next = goal_mv;
    end else if (rising) begin
      present_mv_next = present_mv + ramp_step_mv;
    end else begin
      present_mv_next = present_mv - ramp_step_mv;
    end
  end

  always_comb begin
    amps_raw  = (load_mohm == '0) ? '0 : quotient;
    amps      = ((current_limit_ma != '0) && (amps_raw > current_limit_ma))
                ? current_limit_ma : amps_raw;
    unchanged = sent_valid && (present_mv == sent_mv) && (amps == sent_ma);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_mv           <= slm_pkg::RESET_MIN_MV;
      max_mv           <= slm_pkg::RESET_MAX_MV;
      ramp_step_mv     <= slm_pkg::RESET_STEP_MV;
      current_limit_ma <= slm_pkg::RESET_LIMIT_MA;
    end else if (cfg_we) begin
      unique case (slm_pkg::reg_index_t'(cfg_index))
        slm_pkg::REG_MIN_MV:   min_mv           <= cfg_data[slm_pkg::MV_W-1:0];
        slm_pkg::REG_MAX_MV:   max_mv           <= cfg_data[slm_pkg::MV_W-1:0];
        slm_pkg::REG_STEP_MV:  ramp_step_mv     <= cfg_data[slm_pkg::MV_W-1:0];
        slm_pkg::REG_LIMIT_MA: current_limit_ma <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= slm_pkg::ST_IDLE;
      target_mv  <= slm_pkg::RESET_TARGET_MV;
      output_on  <= 1'b1;
      load_mohm  <= '0;
      present_mv <= '0;
      sent_mv    <= '0;
      sent_ma    <= '0;
      sent_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        unique case (slm_pkg::mode_t'(mode))
          slm_pkg::MODE_SETPOINT: target_mv  <= clamped_mv;
          slm_pkg::MODE_ENABLE:   output_on  <= (value != '0);
          slm_pkg::MODE_LOAD:     load_mohm  <= load_value;
          slm_pkg::MODE_TICK:     present_mv <= present_mv_next;
          default: ;
        endcase
      end
      if ((state == slm_pkg::ST_CHECK) && !unchanged) begin
        sent_valid <= 1'b1;
        sent_mv    <= present_mv;
        sent_ma    <= amps;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == slm_pkg::ST_MUL) begin
      product <= slm_pkg::MA_W'(present_mv * slm_pkg::MV_TO_MA_SCALE);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      slm_pkg::ST_IDLE: begin
        if (accept && (slm_pkg::mode_t'(mode) == slm_pkg::MODE_TICK)) begin
          state_next = slm_pkg::ST_MUL;
        end
      end
      slm_pkg::ST_MUL: begin
        state_next = slm_pkg::ST_START;
      end
      slm_pkg::ST_START: begin
        state_next = (load_mohm == '0) ? slm_pkg::ST_CHECK : slm_pkg::ST_DIV;
      end
      slm_pkg::ST_DIV: begin
        if (div_status.done) begin
          state_next = slm_pkg::ST_CHECK;
        end
      end
      slm_pkg::ST_CHECK: begin
        state_next = unchanged ? slm_pkg::ST_IDLE : slm_pkg::ST_SEND;
      end
      slm_pkg::ST_SEND: begin
        if (out_ready) begin
          state_next = slm_pkg::ST_IDLE;
        end
      end
      default: state_next = slm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == slm_pkg::ST_IDLE);
    out_valid = (state == slm_pkg::ST_SEND);
    div_start = (state == slm_pkg::ST_START) && (load_mohm != '0);
  end

  slm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (load_mohm),
    .quotient (quotient),
    .status   (div_status)
  );

  assign voltage_mv = sent_mv;
  assign current_ma = sent_ma;

endmodule
